// ----- rtl/core/htmb_pkg.sv -----
// htmb_pkg: shared types and constants for the hex text markup to bytes core
// no dependencies; imported by htmb_decode, the top level and the checker
package htmb_pkg;

  // width of the internal saturating byte counter
  localparam int unsigned CountWidth = 32;
  // width of the byte count field on the result stream
  localparam int unsigned CountOutWidth = 32;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned NibbleWidth = 4;
  localparam int unsigned StatusWidth = 3;
  // result tdata: data_byte then byte_count
  localparam int unsigned OutDataWidth = CharWidth + CountOutWidth;

  // parser modes, one-hot
  typedef enum logic [6:0] {
    MODE_IDLE     = 7'b000_0001,
    MODE_COMMENT  = 7'b000_0010,
    MODE_HEX2     = 7'b000_0100,
    MODE_STRING   = 7'b000_1000,
    MODE_STR_ESC  = 7'b001_0000,
    MODE_BARE_ESC = 7'b010_0000,
    MODE_HALTED   = 7'b100_0000
  } mode_e;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_BYTE    = 3'd0,
    ST_FINISH  = 3'd1,
    ST_BAD_HEX = 3'd2,
    ST_BAD_ESC = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  // what the decoder makes of one character
  typedef struct packed {
    mode_e                  mode_next;
    logic [NibbleWidth-1:0] nibble_next;
    logic                   emit;
    logic                   count_inc;
    status_e                status;
    logic [CharWidth-1:0]   data;
  } step_t;

  // counter as seen on the result: clamped to the output field
  function automatic logic [CountOutWidth-1:0] clamp_count(
    input logic [CountWidth-1:0] cnt
  );
    logic [CountWidth+CountOutWidth-1:0] wide;
    wide = {{CountOutWidth{1'b0}}, cnt};
    if (wide[CountWidth+CountOutWidth-1:CountOutWidth] != '0) begin
      return '1;
    end
    return wide[CountOutWidth-1:0];
  endfunction

endpackage

// ----- rtl/core/htmb_decode.sv -----
// htmb_decode: per-character parse step, pure combinational
// depends on htmb_pkg for mode, status and step types
module htmb_decode
  import htmb_pkg::*;
(
  input  mode_e                  mode_i,
  input  logic [NibbleWidth-1:0] nibble_i,
  input  logic [CharWidth-1:0]   char_i,
  input  logic                   end_i,
  output step_t                  step_o
);

  localparam logic [CharWidth-1:0] ChLf        = 8'h0A;
  localparam logic [CharWidth-1:0] ChCr        = 8'h0D;
  localparam logic [CharWidth-1:0] ChTab       = 8'h09;
  localparam logic [CharWidth-1:0] ChSpace     = 8'h20;
  localparam logic [CharWidth-1:0] ChColon     = 8'h3A;
  localparam logic [CharWidth-1:0] ChDash      = 8'h2D;
  localparam logic [CharWidth-1:0] ChHash      = 8'h23;
  localparam logic [CharWidth-1:0] ChQuote     = 8'h22;
  localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;

  // hex digit value, bit 4 flags a valid digit
  function automatic logic [NibbleWidth:0] nibble_of(input logic [CharWidth-1:0] ch);
    logic [CharWidth-1:0] lc;
    logic [CharWidth-1:0] diff;
    lc = ch | 8'h20;
    nibble_of = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      diff = ch - 8'h30;
      nibble_of = {1'b1, diff[NibbleWidth-1:0]};
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      diff = lc - 8'h57;
      nibble_of = {1'b1, diff[NibbleWidth-1:0]};
    end
  endfunction

  // escape byte, bit 8 flags a known escape
  function automatic logic [CharWidth:0] escape_of(input logic [CharWidth-1:0] ch);
    case (ch)
      8'h30:   escape_of = {1'b1, 8'h00};
      8'h61:   escape_of = {1'b1, 8'h07};
      8'h62:   escape_of = {1'b1, 8'h08};
      8'h66:   escape_of = {1'b1, 8'h0C};
      8'h6E:   escape_of = {1'b1, 8'h0A};
      8'h72:   escape_of = {1'b1, 8'h0D};
      8'h74:   escape_of = {1'b1, 8'h09};
      8'h76:   escape_of = {1'b1, 8'h0B};
      8'h5C:   escape_of = {1'b1, 8'h5C};
      8'h27:   escape_of = {1'b1, 8'h27};
      8'h22:   escape_of = {1'b1, 8'h22};
      8'h3F:   escape_of = {1'b1, 8'h3F};
      default: escape_of = '0;
    endcase
  endfunction

  logic [NibbleWidth:0] nib;
  logic [CharWidth:0]   esc;
  logic                 skip_ch;

  assign nib = nibble_of(char_i);
  assign esc = escape_of(char_i);
  assign skip_ch = (char_i == ChSpace) || (char_i >= ChTab && char_i <= ChCr)
                 || (char_i == ChColon) || (char_i == ChDash);

  // top-level character classes, shared by idle mode and the default branch
  function automatic step_t idle_step(input step_t base);
    step_t s;
    s = base;
    s.mode_next = MODE_IDLE;
    if (skip_ch) begin
      s.mode_next = MODE_IDLE;
    end else if (char_i == ChHash) begin
      s.mode_next = MODE_COMMENT;
    end else if (nib[NibbleWidth]) begin
      s.nibble_next = nib[NibbleWidth-1:0];
      s.mode_next   = MODE_HEX2;
    end else if (char_i == ChQuote) begin
      s.mode_next = MODE_STRING;
    end else if (char_i == ChBackslash) begin
      s.mode_next = MODE_BARE_ESC;
    end else begin
      s.mode_next = MODE_HALTED;
      s.emit      = 1'b1;
      s.status    = ST_UNKNOWN;
    end
    return s;
  endfunction

  always_comb begin
    step_t s;
    s.mode_next   = mode_i;
    s.nibble_next = nibble_i;
    s.emit        = 1'b0;
    s.count_inc   = 1'b0;
    s.status      = ST_BYTE;
    s.data        = '0;

    if (mode_i == MODE_HALTED) begin
      s.mode_next = MODE_HALTED;
    end else if (end_i) begin
      s.mode_next = MODE_HALTED;
      s.emit      = 1'b1;
      if (mode_i == MODE_HEX2) begin
        s.status = ST_BAD_HEX;
      end else if (mode_i == MODE_STR_ESC) begin
        s.status = ST_BAD_ESC;
      end else begin
        s.status = ST_FINISH;
      end
    end else begin
      case (mode_i)
        MODE_IDLE: begin
          s = idle_step(s);
        end
        MODE_COMMENT: begin
          if (char_i == ChLf || char_i == ChCr) begin
            s.mode_next = MODE_IDLE;
          end
        end
        MODE_HEX2: begin
          s.emit = 1'b1;
          if (nib[NibbleWidth]) begin
            s.mode_next = MODE_IDLE;
            s.count_inc = 1'b1;
            s.data      = {nibble_i, nib[NibbleWidth-1:0]};
          end else begin
            s.mode_next = MODE_HALTED;
            s.status    = ST_BAD_HEX;
          end
        end
        MODE_STRING: begin
          if (char_i == ChQuote) begin
            s.mode_next = MODE_IDLE;
          end else if (char_i == ChBackslash) begin
            s.mode_next = MODE_STR_ESC;
          end else begin
            s.emit      = 1'b1;
            s.count_inc = 1'b1;
            s.data      = char_i;
          end
        end
        MODE_STR_ESC, MODE_BARE_ESC: begin
          s.emit = 1'b1;
          if (esc[CharWidth]) begin
            s.mode_next = (mode_i == MODE_STR_ESC) ? MODE_STRING : MODE_IDLE;
            s.count_inc = 1'b1;
            s.data      = esc[CharWidth-1:0];
          end else begin
            s.mode_next = MODE_HALTED;
            s.status    = ST_BAD_ESC;
          end
        end
        default: begin
          s = idle_step(s);
        end
      endcase
    end
    step_o = s;
  end

endmodule

// ----- rtl/core/hex_text_markup_to_bytes_core.sv -----
// hex_text_markup_to_bytes_core: top level of the text markup to bytes converter
// depends on htmb_pkg and htmb_decode
//
//  channel   | dir | tdata                           | tlast       | tuser
//  ----------+-----+---------------------------------+-------------+--------
//  s_axis    | in  | [7:0] text_char                 | end_of_text | -
//  m_axis    | out | [7:0] data_byte, [39:8] count   | -           | status
//
// one character per cycle unless the output stalls: a transaction lands in
// the input register, the decoder works on it in the next cycle and any result
// goes to the output register; the input register drains only when the output
// register is free or being taken, so a stalled result holds back at most one
// further character
// reset returns the parser to idle with a zero count; after a finish or error
// result the block drops every further character until reset
module hex_text_markup_to_bytes_core
  import htmb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [CharWidth-1:0]    s_axis_tdata_i,   // [7:0] text_char
  input  logic                    s_axis_tlast_i,   // end_of_text
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OutDataWidth-1:0] m_axis_tdata_o,   // [7:0] data_byte, [39:8] byte_count
  output logic [StatusWidth-1:0]  m_axis_tuser_o    // [2:0] status
);

  // input register
  logic                 in_valid_q, in_valid_d;
  logic [CharWidth-1:0] in_char_q;
  logic                 in_end_q;

  // parser state
  mode_e                  mode_q, mode_d;
  logic [NibbleWidth-1:0] nibble_q, nibble_d;
  logic [CountWidth-1:0]  count_q, count_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [OutDataWidth-1:0] out_data_q;
  status_e                 out_status_q;

  step_t step;
  logic  out_free;
  logic  advance;
  logic  in_take;

  htmb_decode u_decode (
    .mode_i   (mode_q),
    .nibble_i (nibble_q),
    .char_i   (in_char_q),
    .end_i    (in_end_q),
    .step_o   (step)
  );

  // the held character moves on when its possible result has a place to go
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    mode_d     = advance ? step.mode_next : mode_q;
    nibble_d   = advance ? step.nibble_next : nibble_q;
    // saturating count, including the byte of this result
    count_d    = count_q;
    if (advance && step.count_inc && count_q != '1) begin
      count_d = count_q + 1'b1;
    end
    out_valid_d = out_free ? (advance && step.emit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mode_q      <= MODE_IDLE;
      nibble_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      mode_q      <= mode_d;
      nibble_q    <= nibble_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
    if (advance && step.emit) begin
      out_data_q   <= {clamp_count(count_d), step.data};
      out_status_q <= step.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ----- rtl/core/htmb_checker.sv -----
// htmb_port_checks: port-level checks on the converter, bound to the top level
// depends on htmb_pkg and hex_text_markup_to_bytes_core
module htmb_port_checks
  import htmb_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tready_o,
  input logic                    m_axis_tvalid_o,
  input logic                    m_axis_tready_i,
  input logic [OutDataWidth-1:0] m_axis_tdata_o,
  input logic [StatusWidth-1:0]  m_axis_tuser_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a finish or error result is the last one
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o != ST_BYTE |=> !m_axis_tvalid_o)
    else $error("result after finish or error");

  // non-byte results carry a zero data byte
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_BYTE |-> m_axis_tdata_o[CharWidth-1:0] == '0)
    else $error("data byte set on a status result");

  // a byte result has counted at least itself
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_BYTE
      |-> m_axis_tdata_o[OutDataWidth-1:CharWidth] != '0)
    else $error("byte result with zero count");

  // with the output register empty the input side is never stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

bind hex_text_markup_to_bytes_core htmb_port_checks u_htmb_port_checks (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
